FILE: design/gfa_pkg.sv
// Shared types, constants and field helpers for the GF(2^m) arithmetic unit.
package gfa_pkg;

  localparam int unsigned GFA_MAX_DEGREE = 8;
  localparam int unsigned POLY_W         = 9;
  localparam int unsigned ELEM_W         = 8;
  localparam int unsigned TBL_DEPTH      = 256;
  localparam int unsigned RED_TERMS      = 16;
  localparam logic [POLY_W-1:0] POLY_RESET = 9'd285;

  localparam logic [2:0] OP_REDUCE  = 3'd0;
  localparam logic [2:0] OP_ANTILOG = 3'd1;
  localparam logic [2:0] OP_LOG     = 3'd2;
  localparam logic [2:0] OP_ADD     = 3'd3;
  localparam logic [2:0] OP_MUL     = 3'd4;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] operand_a;
    logic [7:0]  operand_b;
    logic [15:0] exponent_in;
    logic        minus_infinity;
  } gfa_in_t;

  typedef struct packed {
    logic [7:0] result_value;
    logic [7:0] result_exponent;
    logic       log_of_zero;
    logic       error;
  } gfa_out_t;

  typedef struct packed {
    logic              we;
    logic [ELEM_W-1:0] addr;
    logic [ELEM_W-1:0] data;
  } gfa_wr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_LOOK,
    ST_EXP,
    ST_FIN
  } gfa_state_e;

  function automatic logic [3:0] gfa_degree(input logic [POLY_W-1:0] poly);
    logic [3:0] d;
    d = 4'd0;
    for (int i = 1; i < POLY_W; i++) begin
      if (poly[i]) begin
        d = 4'(i);
      end
    end
    return d;
  endfunction

  function automatic logic [ELEM_W-1:0] gfa_order(input logic [3:0] m);
    logic [POLY_W-1:0] t;
    t = (9'd1 << m) - 9'd1;
    return t[ELEM_W-1:0];
  endfunction

  // Multiplies an element by x and folds the overflow term back in.
  function automatic logic [ELEM_W-1:0] gfa_times_x(input logic [ELEM_W-1:0] w,
                                                    input logic [POLY_W-1:0] poly,
                                                    input logic [3:0] m);
    logic [POLY_W-1:0] t;
    t = {w, 1'b0};
    if (t[m]) begin
      t = t ^ poly;
    end
    return t[ELEM_W-1:0];
  endfunction

endpackage

FILE: design/gfa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module gfa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/gfa_fill.sv
// Table builder: walks the powers of alpha and fills the antilog and log tables.
module gfa_fill (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         start_i,
  input  logic [gfa_pkg::POLY_W-1:0]                   poly_i,
  input  logic [3:0]                                   m_i,
  input  logic [gfa_pkg::ELEM_W-1:0]                   order_i,
  output logic                                         busy_o,
  output gfa_pkg::gfa_wr_t                             al_wr_o,
  output gfa_pkg::gfa_wr_t                             lg_wr_o,
  output logic [gfa_pkg::TBL_DEPTH-1:0]                vld_o,
  output logic [gfa_pkg::RED_TERMS-1:0][gfa_pkg::ELEM_W-1:0] red_o
);
  import gfa_pkg::*;

  logic                  busy_q;
  logic [ELEM_W-1:0]     idx_q;
  logic [ELEM_W-1:0]     w_q;
  logic [TBL_DEPTH-1:0]  vld_q;
  logic [RED_TERMS-1:0][ELEM_W-1:0] red_q;
  logic [ELEM_W-1:0]     last;
  logic                  in_ord;

  // The walk also covers x^0..x^15 so the reduction terms are always complete.
  assign last   = (order_i < 8'(RED_TERMS)) ? 8'(RED_TERMS - 1) : order_i - 8'd1;
  assign in_ord = idx_q < order_i;

  always_comb begin
    al_wr_o.we   = busy_q && in_ord;
    al_wr_o.addr = idx_q;
    al_wr_o.data = w_q;
    // Only the first exponent that reaches an element is kept.
    lg_wr_o.we   = busy_q && in_ord && !vld_q[w_q];
    lg_wr_o.addr = w_q;
    lg_wr_o.data = idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
      w_q    <= 8'd1;
      vld_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
      w_q    <= 8'd1;
      vld_q  <= '0;
    end else if (busy_q) begin
      idx_q <= idx_q + 8'd1;
      w_q   <= gfa_times_x(w_q, poly_i, m_i);
      if (lg_wr_o.we) begin
        vld_q[w_q] <= 1'b1;
      end
      if (idx_q == last) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && (idx_q < 8'(RED_TERMS))) begin
      red_q[idx_q[3:0]] <= w_q;
    end
  end

  assign busy_o = busy_q;
  assign vld_o  = vld_q;
  assign red_o  = red_q;

endmodule

FILE: design/gfa_mod.sv
// Bit-serial remainder of a 16-bit exponent by the group order 2^m-1.
module gfa_mod (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [15:0]                dividend_i,
  input  logic [gfa_pkg::ELEM_W-1:0] order_i,
  output logic                       done_o,
  output logic [gfa_pkg::ELEM_W-1:0] rem_o
);
  import gfa_pkg::*;

  logic              run_q;
  logic              done_q;
  logic [3:0]        cnt_q;
  logic [15:0]       dvd_q;
  logic [ELEM_W-1:0] rem_q;
  logic [ELEM_W:0]   nr;
  logic [ELEM_W:0]   nr_sub;

  assign nr     = {rem_q, dvd_q[15]};
  assign nr_sub = (nr >= {1'b0, order_i}) ? nr - {1'b0, order_i} : nr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      rem_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= dividend_i;
      rem_q  <= '0;
    end else if (run_q) begin
      rem_q <= nr_sub[ELEM_W-1:0];
      dvd_q <= {dvd_q[14:0], 1'b0};
      cnt_q <= cnt_q + 4'd1;
      if (cnt_q == 4'd15) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

FILE: design/gf2m_arithmetic_unit.sv
// Top level of the GF(2^m) arithmetic unit: control, lookup tables and output register.
//
//   channel  direction  handshake                 word
//   cfg      in         cfg_we_i                  cfg_wdata_i (field polynomial)
//   in       in         in_valid_i / in_stall_o   in_data_i (gfa_in_t)
//   out      out        out_valid_o / out_stall_i out_data_o (gfa_out_t)
//
// Reduce, add, error cases and zero operands go straight from idle to the finish state; log makes one log table read.
// Multiply makes two parallel log reads, then one antilog read.
// Antilog runs the serial remainder unit, then makes one antilog read.
// After reset and after each polynomial write the tables are rebuilt,
// one table entry per cycle; no word is taken meanwhile.
// A finished word waits in the output register while the next word is taken.
module gf2m_arithmetic_unit #(
  parameter int unsigned MAX_DEGREE = gfa_pkg::GFA_MAX_DEGREE
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [gfa_pkg::POLY_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  gfa_pkg::gfa_in_t           in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output gfa_pkg::gfa_out_t          out_data_o
);
  import gfa_pkg::*;

  logic [POLY_W-1:0] poly_q;
  logic [3:0]        m;
  logic [ELEM_W-1:0] order;
  logic              deg_bad;

  logic                 fill_busy;
  gfa_wr_t              al_wr;
  gfa_wr_t              lg_wr;
  logic [TBL_DEPTH-1:0] vld;
  logic [RED_TERMS-1:0][ELEM_W-1:0] red;

  logic              mod_start;
  logic              mod_done;
  logic [ELEM_W-1:0] mod_rem;

  logic [ELEM_W-1:0] al_raddr, al_rd;
  logic [ELEM_W-1:0] lga_raddr, lga_rd;
  logic [ELEM_W-1:0] lgb_rd;

  logic [ELEM_W-1:0] ra, rb;
  logic [ELEM_W:0]   esum;
  logic [ELEM_W-1:0] ksum;

  gfa_state_e st_q, st_d;
  logic [2:0] op_q, op_d;
  logic       abig_q, abig_d;
  logic       vlda_q, vldb_q;
  gfa_out_t   res_q, res_d;
  gfa_out_t   out_q;
  logic       out_vld_q;
  logic       in_acc;
  logic       out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= POLY_RESET;
    end else if (cfg_we_i) begin
      poly_q <= cfg_wdata_i;
    end
  end

  assign m       = gfa_degree(poly_q);
  assign order   = gfa_order(m);
  assign deg_bad = (m == 4'd0) || (32'(m) > MAX_DEGREE);

  gfa_fill u_fill (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cfg_we_i),
    .poly_i  (poly_q),
    .m_i     (m),
    .order_i (order),
    .busy_o  (fill_busy),
    .al_wr_o (al_wr),
    .lg_wr_o (lg_wr),
    .vld_o   (vld),
    .red_o   (red)
  );

  gfa_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (in_data_i.exponent_in),
    .order_i    (order),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  gfa_ram #(.WIDTH(ELEM_W), .DEPTH(TBL_DEPTH)) u_antilog (
    .clk_i   (clk_i),
    .we_i    (al_wr.we),
    .waddr_i (al_wr.addr),
    .wdata_i (al_wr.data),
    .raddr_i (al_raddr),
    .rdata_o (al_rd)
  );

  // Two copies of the log table give both multiply operands in one read.
  gfa_ram #(.WIDTH(ELEM_W), .DEPTH(TBL_DEPTH)) u_log_a (
    .clk_i   (clk_i),
    .we_i    (lg_wr.we),
    .waddr_i (lg_wr.addr),
    .wdata_i (lg_wr.data),
    .raddr_i (lga_raddr),
    .rdata_o (lga_rd)
  );

  gfa_ram #(.WIDTH(ELEM_W), .DEPTH(TBL_DEPTH)) u_log_b (
    .clk_i   (clk_i),
    .we_i    (lg_wr.we),
    .waddr_i (lg_wr.addr),
    .wdata_i (lg_wr.data),
    .raddr_i (rb),
    .rdata_o (lgb_rd)
  );

  // Reduction is linear, so it is the XOR of x^j mod p over the set bits.
  always_comb begin
    ra = '0;
    rb = '0;
    for (int j = 0; j < RED_TERMS; j++) begin
      if (in_data_i.operand_a[j]) begin
        ra = ra ^ red[j];
      end
    end
    for (int j = 0; j < ELEM_W; j++) begin
      if (in_data_i.operand_b[j]) begin
        rb = rb ^ red[j];
      end
    end
  end

  assign lga_raddr = (in_data_i.opcode == OP_MUL) ? ra : in_data_i.operand_a[ELEM_W-1:0];

  // Both logs are below the order, so one conditional subtract wraps the sum.
  assign esum = {1'b0, lga_rd} + {1'b0, lgb_rd};
  always_comb begin
    logic [ELEM_W:0] t;
    t    = (esum >= {1'b0, order}) ? esum - {1'b0, order} : esum;
    ksum = t[ELEM_W-1:0];
  end

  assign in_stall_o = (st_q != ST_IDLE) || fill_busy || cfg_we_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (st_q == ST_FIN) && (!out_vld_q || !out_stall_i);

  always_comb begin
    st_d      = st_q;
    op_d      = op_q;
    abig_d    = abig_q;
    res_d     = res_q;
    mod_start = 1'b0;
    al_raddr  = ksum;
    unique case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          op_d   = in_data_i.opcode;
          abig_d = in_data_i.operand_a[15:ELEM_W] != '0;
          res_d  = '0;
          st_d   = ST_FIN;
          if (deg_bad) begin
            res_d.error = 1'b1;
          end else begin
            unique case (in_data_i.opcode)
              OP_REDUCE: res_d.result_value = ra;
              OP_ANTILOG: begin
                if (!in_data_i.minus_infinity) begin
                  mod_start = 1'b1;
                  st_d      = ST_MOD;
                end
              end
              OP_LOG: begin
                if (in_data_i.operand_a == '0) begin
                  res_d.log_of_zero = 1'b1;
                end else begin
                  st_d = ST_LOOK;
                end
              end
              OP_ADD: res_d.result_value = ra ^ rb;
              OP_MUL: begin
                if (ra != '0 && rb != '0) begin
                  st_d = ST_LOOK;
                end
              end
              default: res_d.error = 1'b1;
            endcase
          end
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          al_raddr = mod_rem;
          st_d     = ST_EXP;
        end
      end
      ST_LOOK: begin
        res_d = '0;
        st_d  = ST_FIN;
        if (op_q == OP_LOG) begin
          if (abig_q || !vlda_q) begin
            res_d.error = 1'b1;
          end else begin
            res_d.result_exponent = lga_rd;
          end
        end else if (!vlda_q || !vldb_q) begin
          res_d.error = 1'b1;
        end else begin
          st_d = ST_EXP;
        end
      end
      ST_EXP: begin
        res_d              = '0;
        res_d.result_value = al_rd;
        st_d               = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    abig_q <= abig_d;
    res_q  <= res_d;
    if (in_acc) begin
      vlda_q <= vld[lga_raddr];
      vldb_q <= vld[rb];
    end
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_look_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_LOOK |-> $past(in_acc))
    else $error("lookup state entered without an accepted word");

  a_exp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_EXP |-> $past(st_q) == ST_MOD || $past(st_q) == ST_LOOK)
    else $error("antilog read state entered from an unexpected state");

  a_mod_done_in_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> st_q == ST_MOD)
    else $error("remainder unit finished outside of an antilog operation");

  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.error |->
      out_q.result_value == '0 && out_q.result_exponent == '0 && !out_q.log_of_zero)
    else $error("error word carries nonzero fields");

endmodule
